### design/hts_pkg.sv
// Shared types and constants for the heightfield triangle sampler.
`default_nettype none
package hts_pkg;

  localparam int HEIGHT_W = 16;
  localparam int CELL_W   = 16;
  localparam int POS_W    = 32;
  localparam int INDEX_W  = 13;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [CELL_W-1:0] CELL_EDGE_RESET = 16'd256;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_ADDR,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_MAC0,
    S_MAC1,
    S_MAC2,
    S_HSTART,
    S_HDIV,
    S_RES
  } state_t;

endpackage
`default_nettype wire

### design/heightfield_triangle_sample.sv
// Heightfield sampler: vertex height store and triangle-plane height query.
//
// Input channel (in_valid / in_stall): one transaction per item. mode 0 writes
// in_height_value to vertex in_vertex_index; indices beyond the grid are
// dropped. mode 1 queries the height at (in_pos_x, in_pos_depth).
// Result channel (out_valid / out_stall): one transaction per query, none
// per write. Configuration (cfg_valid / cfg_ready): cfg_data sets the cell
// edge, Q8.8; write it only while no query is in flight.
// A query holds the input stalled until it is done: the cell divisions, three
// height reads on the single RAM port, three multiply-accumulate steps and
// the final floor division. Out-of-grid queries go from the bounds check
// straight to the result, and far-edge queries skip the arithmetic. A write
// does not stall the input.
// The result sits in an output register; the next item is accepted while it
// waits, and a following query holds at its end until the register is free.
// Synchronous reset clears the control state and sets the cell edge to 256;
// the height RAM is not cleared, so a vertex must be written before it is read.
`default_nettype none
module heightfield_triangle_sample #(
  parameter int DIM = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_mode,
  input  wire logic        [hts_pkg::INDEX_W-1:0]   in_vertex_index,
  input  wire logic signed [hts_pkg::HEIGHT_W-1:0]  in_height_value,
  input  wire logic signed [hts_pkg::POS_W-1:0]     in_pos_x,
  input  wire logic signed [hts_pkg::POS_W-1:0]     in_pos_depth,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [hts_pkg::HEIGHT_W-1:0]  out_height,
  output logic                                      out_out_of_bound,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic        [hts_pkg::CELL_W-1:0]    cfg_data
);

  import hts_pkg::*;

  localparam int VCOUNT = (DIM + 1) * (DIM + 1);
  localparam int AW     = $clog2(VCOUNT);
  localparam int PQW    = $clog2(DIM + 1);
  localparam int PSW    = CELL_W + PQW;
  localparam int CMPW   = (AW > INDEX_W) ? AW + 1 : INDEX_W + 1;

  state_t state_r, state_nxt;

  logic [CELL_W-1:0]          cell_edge_r;
  logic signed [POS_W-1:0]    x_r, u_r;
  logic [PQW-1:0]             col_r, row_r;
  logic [CELL_W-1:0]          fx_r, fu_r, g1_r, g2_r;
  logic [AW-1:0]              base_r;
  logic                       edge_r, upper_r;
  logic signed [HEIGHT_W-1:0] hb_r, ha_r, hc_r;
  logic signed [35:0]         acc_r;
  logic [HEIGHT_W-1:0]        res_h_r;
  logic                       res_oob_r;
  logic                       out_valid_r;
  logic [HEIGHT_W-1:0]        out_h_r;
  logic                       out_oob_r;

  logic accept, out_take, out_free;
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  // bounds
  logic [PSW-1:0] size;
  logic           oob;
  assign size = PSW'(DIM) * PSW'(cell_edge_r);
  assign oob  = (cell_edge_r == '0) || x_r[POS_W-1] || u_r[POS_W-1]
             || ({1'b0, x_r[POS_W-2:0]} > POS_W'(size))
             || ({1'b0, u_r[POS_W-2:0]} > POS_W'(size));

  // cell division
  logic           div_start;
  logic           dx_done, du_done;
  logic [PQW-1:0] dx_q, du_q;
  logic [POS_W-2:0] dx_rem, du_rem;

  assign div_start = (state_r == S_CHECK) && !oob;

  hts_div #(.NW(POS_W - 1), .DW(CELL_W), .QW(PQW)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(x_r[POS_W-2:0]),
    .den(cell_edge_r), .done(dx_done), .quot(dx_q), .rem(dx_rem)
  );

  hts_div #(.NW(POS_W - 1), .DW(CELL_W), .QW(PQW)) u_div_u (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(u_r[POS_W-2:0]),
    .den(cell_edge_r), .done(du_done), .quot(du_q), .rem(du_rem)
  );

  // triangle choice
  logic [CELL_W:0] fsum;
  logic            upper_c;
  assign fsum    = {1'b0, fx_r} + {1'b0, fu_r};
  assign upper_c = (fsum >= {1'b0, cell_edge_r})
                && (col_r != PQW'(DIM)) && (row_r != PQW'(DIM));

  // height RAM
  logic            ram_we;
  logic [AW-1:0]   ram_addr, rd_addr;
  logic [HEIGHT_W-1:0] ram_rdata;

  always_comb begin
    case (state_r)
      S_RD0:   rd_addr = upper_r ? base_r + AW'(DIM + 2) : base_r;
      S_RD1:   rd_addr = upper_r ? base_r + AW'(DIM + 1) : base_r + AW'(1);
      S_RD2:   rd_addr = upper_r ? base_r + AW'(1) : base_r + AW'(DIM + 1);
      default: rd_addr = base_r;
    endcase
  end

  assign ram_we   = accept && (in_mode == MODE_WRITE)
                 && (CMPW'(in_vertex_index) < CMPW'(VCOUNT));
  assign ram_addr = (state_r == S_IDLE) ? AW'(in_vertex_index) : rd_addr;

  hts_ram #(.WIDTH(HEIGHT_W), .DEPTH(VCOUNT)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_height_value),
    .rdata(ram_rdata)
  );

  // multiply-accumulate
  logic signed [17:0] op_a;
  logic signed [16:0] op_b;
  logic signed [34:0] prod;

  always_comb begin
    case (state_r)
      S_MAC1: begin
        op_a = 18'(ha_r) - 18'(hb_r);
        op_b = {1'b0, g1_r};
      end
      S_MAC2: begin
        op_a = 18'(hc_r) - 18'(hb_r);
        op_b = {1'b0, g2_r};
      end
      default: begin
        op_a = 18'(hb_r);
        op_b = {1'b0, cell_edge_r};
      end
    endcase
  end

  assign prod = op_a * op_b;

  // final floor division, offset to keep the dividend non-negative
  logic               h_start, dh_done;
  logic [HEIGHT_W-1:0] dh_q;
  logic [31:0]        dh_rem;
  logic signed [35:0] hnum;

  assign hnum    = acc_r + $signed({5'b0, cell_edge_r, 15'b0});
  assign h_start = (state_r == S_HSTART);

  hts_div #(.NW(32), .DW(CELL_W), .QW(HEIGHT_W)) u_div_h (
    .clk(clk), .rst_n(rst_n), .start(h_start), .num(hnum[31:0]),
    .den(cell_edge_r), .done(dh_done), .quot(dh_q), .rem(dh_rem)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept && in_mode == MODE_QUERY) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = oob ? S_RES : S_DIV;
      S_DIV:    if (dx_done) state_nxt = S_ADDR;
      S_ADDR:   state_nxt = S_RD0;
      S_RD0:    state_nxt = S_RD1;
      S_RD1:    state_nxt = edge_r ? S_RES : S_RD2;
      S_RD2:    state_nxt = S_RD3;
      S_RD3:    state_nxt = S_MAC0;
      S_MAC0:   state_nxt = S_MAC1;
      S_MAC1:   state_nxt = S_MAC2;
      S_MAC2:   state_nxt = S_HSTART;
      S_HSTART: state_nxt = S_HDIV;
      S_HDIV:   if (dh_done) state_nxt = S_RES;
      S_RES:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cell_edge_r <= CELL_EDGE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cell_edge_r <= cfg_data;
      end
      if (state_r == S_RES && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_pos_x;
      u_r <= in_pos_depth;
    end
    case (state_r)
      S_CHECK: begin
        res_h_r   <= '0;
        res_oob_r <= 1'b1;
      end
      S_DIV: begin
        col_r <= dx_q;
        row_r <= du_q;
        fx_r  <= CELL_W'(dx_rem);
        fu_r  <= CELL_W'(du_rem);
      end
      S_ADDR: begin
        base_r  <= AW'(row_r) * AW'(DIM + 1) + AW'(col_r);
        edge_r  <= (col_r == PQW'(DIM)) || (row_r == PQW'(DIM));
        upper_r <= upper_c;
        g1_r    <= upper_c ? cell_edge_r - fx_r : fx_r;
        g2_r    <= upper_c ? cell_edge_r - fu_r : fu_r;
      end
      S_RD1: begin
        hb_r      <= ram_rdata;
        res_h_r   <= ram_rdata;
        res_oob_r <= 1'b0;
      end
      S_RD2:  ha_r  <= ram_rdata;
      S_RD3:  hc_r  <= ram_rdata;
      S_MAC0: acc_r <= 36'(prod);
      S_MAC1: acc_r <= acc_r + 36'(prod);
      S_MAC2: acc_r <= acc_r + 36'(prod);
      S_HDIV: if (dh_done) res_h_r <= {~dh_q[HEIGHT_W-1], dh_q[HEIGHT_W-2:0]};
      default: ;
    endcase
    if (state_r == S_RES && out_free) begin
      out_h_r   <= res_h_r;
      out_oob_r <= res_oob_r;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_height       = out_h_r;
  assign out_out_of_bound = out_oob_r;

  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_bound |-> out_height == '0)
    else $error("out-of-grid result with non-zero height");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == MODE_QUERY |=> state_r == S_CHECK)
    else $error("accepted query did not start");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dx_done == du_done)
    else $error("cell dividers out of step");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD0 |-> fx_r < cell_edge_r && fu_r < cell_edge_r)
    else $error("cell fraction not below cell edge");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RES)
    else $error("result raised outside result state");

endmodule
`default_nettype wire

### design/hts_ram.sv
// Single-port synchronous RAM with registered read data.
`default_nettype none
module hts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4225
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### design/hts_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module hts_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [QW-1:0]      quot,
  output logic [NW-1:0]      rem
);

  localparam int SW = DW + QW - 1;
  localparam int LW = (NW > SW) ? NW : SW;
  localparam int CW = (QW > 1) ? $clog2(QW) : 1;

  logic [NW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] dsh_r, dsh_nxt;
  logic [QW-1:0] quot_r, quot_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          fits;

  assign fits = LW'(rem_r) >= LW'(dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = SW'(den) << (QW - 1);
      cnt_nxt  = CW'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - NW'(dsh_r);
      end
      quot_nxt = QW'({quot_r, fits});
      dsh_nxt  = dsh_r >> 1;
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire
